// ===== rtl/bfha_pkg.sv =====
// Shared types and codes for the best-fit heap allocator.
// Used by the allocator core, the checker and the testbench; no dependencies.
package bfha_pkg;

   localparam logic [1:0] CMD_ALLOC  = 2'd0;
   localparam logic [1:0] CMD_FREE   = 2'd1;
   localparam logic [1:0] CMD_FORMAT = 2'd2;

   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_NOFIT = 2'd1;
   localparam logic [1:0] STAT_ZERO  = 2'd2;
   localparam logic [1:0] STAT_IGN   = 2'd3;

   localparam logic [31:0] TAIL_WORD = 32'd1;
   localparam int          FIRST_HDR = 4;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] request_bytes;
      logic [15:0] block_offset;
   } req_type;

   typedef struct packed {
      logic [15:0] payload_offset;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_FMT0, ST_FMT1, ST_FMT2, ST_IDLE,
      ST_A_WALK, ST_A_SP1, ST_A_SP2, ST_A_SP3, ST_A_EX1, ST_A_EX2,
      ST_F_HDR, ST_F_FOOT, ST_F_NXT, ST_F_NFOOT, ST_F_BACK, ST_F_PSZ,
      ST_F_PH, ST_F_PFOOT, ST_RESP
   } state_type;

endpackage

// ===== rtl/best_fit_heap_allocator_core.sv =====
// Best-fit heap allocator core over an implicit block list in one word RAM.
// Depends on bfha_pkg and bfha_ram.
//
// Issue a transaction by raising start while busy is low; busy then stays
// high until the single result strobe (rsp_valid, one cycle, cannot be held
// off). After reset the core clears all HEAP_BYTES/4 words, one per cycle,
// and writes the three format words, with busy high throughout. An allocate
// reads one block header per walk step (up to (HEAP_BYTES-8)/8 blocks, one
// RAM read each), then splits the best block by writing the remainder
// header, remainder footer and block header, or takes the whole block and
// sets the next block's previous-allocated bit, or goes straight to the
// result when nothing fits. A free marks its header and footer and merges
// with free neighbours, or goes straight to the result when its header is
// rejected; a format rewrites the three format words; a zero-size request,
// a misaligned or out-of-range free or an unused command goes straight to it.
module best_fit_heap_allocator_core
   import bfha_pkg::*;
#(
   parameter int HEAP_BYTES = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int WORD_COUNT = HEAP_BYTES / 4;
   localparam int WA         = $clog2(WORD_COUNT);
   localparam int OW         = WA + 2;
   localparam int USABLE     = ((HEAP_BYTES - 8) / 8) * 8;
   localparam int END_POS    = FIRST_HDR + USABLE;
   localparam logic [31:0] END32 = 32'(END_POS);
   localparam logic [31:0] HDR32 = 32'(FIRST_HDR);

   state_type state_ff, state_in;

   logic [WA-1:0] clr_ff, clr_in;
   logic          fmtcmd_ff, fmtcmd_in;
   logic [OW-1:0] cur_ff, cur_in;
   logic [OW-1:0] best_ff, best_in;
   logic [31:0]   bw_ff, bw_in;
   logic [31:0]   bsz_ff, bsz_in;
   logic          have_ff, have_in;
   logic [17:0]   need_ff, need_in;
   logic [OW-1:0] h_ff, h_in;
   logic [31:0]   w_ff, w_in;
   logic [31:0]   nsz_ff, nsz_in;
   logic [31:0]   foot_ff, foot_in;
   logic [31:0]   footv_ff, footv_in;
   logic [31:0]   psz_ff, psz_in;
   logic [OW-1:0] ph_ff, ph_in;
   logic [15:0]   pay_ff, pay_in;
   logic [1:0]    stat_ff, stat_in;

   logic          we;
   logic [31:0]   wbyte;
   logic [31:0]   wdata;
   logic [31:0]   rbyte;
   logic [31:0]   rdata;
   logic          we_ok;

   // Walk decode of the header word just read
   logic [31:0] sz, room, nxt32, rem;
   logic        blk_bad, hit_exact, better, more, have_after, do_split;
   // Free decode
   logic [31:0] off32, h32, hroom;
   logic        free_rej, hdr_bad, back_ok;

   bfha_ram #(.WIDTH(32), .DEPTH(WORD_COUNT)) u_ram (
      .clock  (clock),
      .wr_en  (we_ok),
      .wr_addr(wbyte[WA+1:2]),
      .wr_data(wdata),
      .rd_addr(rbyte[WA+1:2]),
      .rd_data(rdata)
   );

   // Drop writes that land beyond the heap
   assign we_ok = we && ((wbyte >> 2) < 32'(WORD_COUNT));

   always_comb begin
      sz         = {rdata[31:3], 3'b000};
      room       = END32 - 32'(cur_ff);
      nxt32      = 32'(cur_ff) + sz;
      blk_bad    = (rdata == TAIL_WORD) || (sz == 32'd0) || (sz > room);
      hit_exact  = !blk_bad && !rdata[0] && (sz == 32'(need_ff));
      better     = !blk_bad && !rdata[0] && (sz > 32'(need_ff)) &&
                   (!have_ff || (bsz_ff > sz));
      more       = !blk_bad && !hit_exact && (nxt32 < END32);
      have_after = have_ff || better;
      rem        = (better ? sz : bsz_ff) - 32'(need_ff);
      do_split   = rem >= 32'd8;
      off32      = 32'(req_data.block_offset);
      h32        = off32 - 32'd4;
      free_rej   = (off32[2:0] != 3'd0) || (off32 < HDR32 + 32'd4) || (h32 >= END32);
      hroom      = END32 - 32'(h_ff);
      hdr_bad    = !rdata[0] || (sz == 32'd0) || (sz > hroom);
      back_ok    = (rdata != 32'd0) && (rdata <= 32'(h_ff) - HDR32);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_ff == WA'(WORD_COUNT - 1)) state_in = ST_FMT0;
         ST_FMT0:   state_in = ST_FMT1;
         ST_FMT1:   state_in = ST_FMT2;
         ST_FMT2:   state_in = fmtcmd_ff ? ST_RESP : ST_IDLE;
         ST_IDLE: begin
            if (start) begin
               unique case (req_data.command)
                  CMD_ALLOC:  state_in = (req_data.request_bytes == 16'd0) ?
                                         ST_RESP : ST_A_WALK;
                  CMD_FREE:   state_in = free_rej ? ST_RESP : ST_F_HDR;
                  CMD_FORMAT: state_in = ST_FMT0;
                  default:    state_in = ST_RESP;
               endcase
            end
         end
         ST_A_WALK: begin
            if (more) state_in = ST_A_WALK;
            else if (hit_exact) state_in = ST_A_EX1;
            else if (!have_after) state_in = ST_RESP;
            else if (do_split) state_in = ST_A_SP1;
            else state_in = ST_A_EX1;
         end
         ST_A_SP1:  state_in = ST_A_SP2;
         ST_A_SP2:  state_in = ST_A_SP3;
         ST_A_SP3:  state_in = ST_RESP;
         ST_A_EX1:  state_in = ST_A_EX2;
         ST_A_EX2:  state_in = ST_RESP;
         ST_F_HDR:  state_in = hdr_bad ? ST_RESP : ST_F_FOOT;
         ST_F_FOOT: state_in = ST_F_NXT;
         ST_F_NXT:  state_in = (rdata != TAIL_WORD && !rdata[0]) ? ST_F_NFOOT : ST_F_BACK;
         ST_F_NFOOT: state_in = ST_F_BACK;
         ST_F_BACK: state_in = (w_ff[2:1] == 2'b00) ? ST_F_PSZ : ST_RESP;
         ST_F_PSZ:  state_in = back_ok ? ST_F_PH : ST_RESP;
         ST_F_PH:   state_in = ST_F_PFOOT;
         ST_F_PFOOT: state_in = ST_RESP;
         ST_RESP:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory controls
   always_comb begin
      clr_in    = clr_ff;
      fmtcmd_in = fmtcmd_ff;
      cur_in    = cur_ff;
      best_in   = best_ff;
      bw_in     = bw_ff;
      bsz_in    = bsz_ff;
      have_in   = have_ff;
      need_in   = need_ff;
      h_in      = h_ff;
      w_in      = w_ff;
      nsz_in    = nsz_ff;
      foot_in   = foot_ff;
      footv_in  = footv_ff;
      psz_in    = psz_ff;
      ph_in     = ph_ff;
      pay_in    = pay_ff;
      stat_in   = stat_ff;
      we        = 1'b0;
      wbyte     = 32'd0;
      wdata     = 32'd0;
      rbyte     = 32'd0;
      unique case (state_ff)
         ST_CLEAR: begin
            // Zero one word per cycle
            we     = 1'b1;
            wbyte  = {{(30-WA){1'b0}}, clr_ff, 2'b00};
            clr_in = clr_ff + WA'(1);
         end
         ST_FMT0: begin
            we = 1'b1; wbyte = HDR32; wdata = 32'(USABLE) + 32'd2;
         end
         ST_FMT1: begin
            we = 1'b1; wbyte = HDR32 + 32'(USABLE) - 32'd4; wdata = 32'(USABLE);
         end
         ST_FMT2: begin
            we = 1'b1; wbyte = END32; wdata = TAIL_WORD;
         end
         ST_IDLE: begin
            if (start) begin
               pay_in    = 16'd0;
               stat_in   = STAT_DONE;
               fmtcmd_in = 1'b1;
               unique case (req_data.command)
                  CMD_ALLOC: begin
                     if (req_data.request_bytes == 16'd0) stat_in = STAT_ZERO;
                     need_in = (18'(req_data.request_bytes) + 18'd11) & ~18'd7;
                     cur_in  = OW'(FIRST_HDR);
                     have_in = 1'b0;
                     rbyte   = HDR32;
                  end
                  CMD_FREE: begin
                     if (free_rej) stat_in = STAT_IGN;
                     h_in  = h32[OW-1:0];
                     rbyte = h32;
                  end
                  CMD_FORMAT: ;
                  default: stat_in = STAT_IGN;
               endcase
            end
         end
         ST_A_WALK: begin
            // Keep the best candidate and fetch the next header
            if (hit_exact || better) begin
               best_in = cur_ff;
               bw_in   = rdata;
               bsz_in  = sz;
               have_in = 1'b1;
            end
            cur_in = nxt32[OW-1:0];
            rbyte  = nxt32;
            if (!more && !hit_exact && !have_after) stat_in = STAT_NOFIT;
         end
         ST_A_SP1: begin
            we    = 1'b1;
            wbyte = 32'(best_ff) + 32'(need_ff);
            wdata = bsz_ff - 32'(need_ff) + 32'd2;
         end
         ST_A_SP2: begin
            we    = 1'b1;
            wbyte = 32'(best_ff) + bsz_ff - 32'd4;
            wdata = bsz_ff - 32'(need_ff);
         end
         ST_A_SP3: begin
            we     = 1'b1;
            wbyte  = 32'(best_ff);
            wdata  = (bw_ff & 32'd2) + 32'(need_ff) + 32'd1;
            pay_in = 16'(32'(best_ff) + 32'd4);
         end
         ST_A_EX1: begin
            we    = 1'b1;
            wbyte = 32'(best_ff);
            wdata = bw_ff + 32'd1;
            rbyte = 32'(best_ff) + ((bw_ff + 32'd1) & ~32'd7);
         end
         ST_A_EX2: begin
            // Set the next block's previous-allocated bit
            we     = (rdata != TAIL_WORD);
            wbyte  = 32'(best_ff) + ((bw_ff + 32'd1) & ~32'd7);
            wdata  = rdata + 32'd2;
            pay_in = 16'(32'(best_ff) + 32'd4);
         end
         ST_F_HDR: begin
            if (hdr_bad) begin
               stat_in = STAT_IGN;
            end else begin
               we       = 1'b1;
               wbyte    = 32'(h_ff);
               wdata    = rdata - 32'd1;
               w_in     = rdata - 32'd1;
               bsz_in   = sz;
               nsz_in   = 32'd0;
               foot_in  = 32'(h_ff) + sz - 32'd4;
               footv_in = sz;
            end
         end
         ST_F_FOOT: begin
            we    = 1'b1;
            wbyte = foot_ff;
            wdata = bsz_ff;
            rbyte = 32'(h_ff) + bsz_ff;
         end
         ST_F_NXT: begin
            if (rdata != TAIL_WORD) begin
               we = 1'b1;
               if (rdata[0]) begin
                  wbyte = 32'(h_ff) + bsz_ff;
                  wdata = rdata - 32'd2;
               end else begin
                  // Merge forward
                  nsz_in   = {rdata[31:3], 3'b000};
                  w_in     = w_ff + {rdata[31:3], 3'b000};
                  wbyte    = 32'(h_ff);
                  wdata    = w_ff + {rdata[31:3], 3'b000};
                  foot_in  = 32'(h_ff) + bsz_ff + {rdata[31:3], 3'b000} - 32'd4;
                  footv_in = bsz_ff + {rdata[31:3], 3'b000};
               end
            end
         end
         ST_F_NFOOT: begin
            we = 1'b1; wbyte = foot_ff; wdata = footv_ff;
         end
         ST_F_BACK: begin
            rbyte = 32'(h_ff) - 32'd4;
         end
         ST_F_PSZ: begin
            psz_in = rdata;
            ph_in  = OW'(32'(h_ff) - rdata);
            rbyte  = 32'(h_ff) - rdata;
         end
         ST_F_PH: begin
            // Merge backward
            we    = 1'b1;
            wbyte = 32'(ph_ff);
            wdata = rdata + bsz_ff + nsz_ff;
         end
         ST_F_PFOOT: begin
            we = 1'b1; wbyte = foot_ff; wdata = footv_ff + psz_ff;
         end
         ST_RESP: fmtcmd_in = 1'b0;
         default: ;
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         fmtcmd_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         fmtcmd_ff <= fmtcmd_in;
      end
      cur_ff   <= cur_in;
      best_ff  <= best_in;
      bw_ff    <= bw_in;
      bsz_ff   <= bsz_in;
      have_ff  <= have_in;
      need_ff  <= need_in;
      h_ff     <= h_in;
      w_ff     <= w_in;
      nsz_ff   <= nsz_in;
      foot_ff  <= foot_in;
      footv_ff <= footv_in;
      psz_ff   <= psz_in;
      ph_ff    <= ph_in;
      pay_ff   <= pay_in;
      stat_ff  <= stat_in;
   end

   assign busy                    = (state_ff != ST_IDLE);
   assign rsp_valid               = (state_ff == ST_RESP);
   assign rsp_data.payload_offset = pay_ff;
   assign rsp_data.status         = stat_ff;

   // Checks
   a_strobe_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted transaction did not raise busy");
   a_pay_align: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.payload_offset[2:0] == 3'd0))
      else $error("payload offset misaligned");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STAT_DONE) |-> (rsp_data.payload_offset == 16'd0))
      else $error("failed transaction returned an offset");
   a_idle_nowrite: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !we) else $error("heap written while idle");

endmodule

// ===== rtl/bfha_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bfha_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and read; read data is registered and appears in the next cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== test/bfha_checker.sv =====
// Result checker for the best-fit heap allocator core: keeps a word-level
// heap image, predicts each result and compares. Depends on bfha_pkg.
`timescale 1ns / 1ps
module bfha_checker
   import bfha_pkg::*;
#(
   parameter int HEAP_BYTES = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);
   localparam int WORDS = HEAP_BYTES / 4;
   localparam logic [31:0] USABLE = (HEAP_BYTES - 8) & ~7;
   localparam logic [31:0] END_POS = FIRST_HDR + USABLE;

   logic [31:0] heap_image [WORDS];
   rsp_type     expected_rsp [$];

   function automatic logic [31:0] peek(logic [31:0] b);
      return ((b >> 2) < WORDS) ? heap_image[b >> 2] : 32'd0;
   endfunction

   function automatic void poke(logic [31:0] b, logic [31:0] v);
      if ((b >> 2) < WORDS) heap_image[b >> 2] = v;
   endfunction

   function automatic void format_image();
      poke(FIRST_HDR, USABLE + 2);
      poke(FIRST_HDR + USABLE - 4, USABLE);
      poke(END_POS, TAIL_WORD);
   endfunction

   function automatic rsp_type allocate_block(logic [31:0] req);
      rsp_type r;
      logic [31:0] need, cur, best, best_sz, w, sz, rem, nh, nxt;
      bit have, exact;
      r = '0;
      best = 0; best_sz = 0; have = 0; exact = 0;
      if (req == 0) begin
         r.status = STAT_ZERO;
         return r;
      end
      need = (4 + req + 7) & ~32'd7;
      cur = FIRST_HDR;
      // walk the implicit list, stop on end mark, corrupt size or exact fit
      while (cur < END_POS) begin
         w = peek(cur);
         sz = w & ~32'd7;
         if (w == TAIL_WORD || sz == 0 || sz > END_POS - cur) break;
         if (!w[0]) begin
            if (sz == need) begin
               best = cur; best_sz = sz; have = 1; exact = 1;
               break;
            end
            if (sz > need && (!have || best_sz > sz)) begin
               best = cur; best_sz = sz; have = 1;
            end
         end
         cur += sz;
      end
      if (!have) begin
         r.status = STAT_NOFIT;
         return r;
      end
      if (!exact && best_sz - need >= 8) begin
         rem = best_sz - need;
         nh = best + need;
         poke(nh, rem + 2);
         poke(nh + rem - 4, rem);
         poke(best, (peek(best) & 2) + need + 1);
      end else begin
         poke(best, peek(best) + 1);
         nxt = best + (peek(best) & ~32'd7);
         if (peek(nxt) != TAIL_WORD) poke(nxt, peek(nxt) + 2);
      end
      r.payload_offset = 16'(best + 4);
      r.status = STAT_DONE;
      return r;
   endfunction

   function automatic logic [1:0] free_block(logic [31:0] off);
      logic [31:0] h, w, bsz, foot, nxt, nw, nsz, psz, ph;
      nsz = 0;
      if ((off & 7) != 0 || off < FIRST_HDR + 4) return STAT_IGN;
      h = off - 4;
      if (h >= END_POS) return STAT_IGN;
      w = peek(h);
      if (!w[0]) return STAT_IGN;
      bsz = w & ~32'd7;
      if (bsz == 0 || bsz > END_POS - h) return STAT_IGN;
      w -= 1;
      poke(h, w);
      foot = h + bsz - 4;
      poke(foot, bsz);
      // merge forward or clear the next block's previous bit
      nxt = h + bsz;
      nw = peek(nxt);
      if (nw != TAIL_WORD) begin
         if (nw[0]) poke(nxt, nw - 2);
         else begin
            nsz = nw & ~32'd7;
            w += nsz;
            poke(h, w);
            foot = h + bsz + nsz - 4;
            poke(foot, bsz + nsz);
         end
      end
      // merge backward when the previous block is free
      if ((w & 7) < 2) begin
         psz = peek(h - 4);
         if (psz != 0 && psz <= h - FIRST_HDR) begin
            ph = h - psz;
            poke(ph, peek(ph) + bsz + nsz);
            poke(foot, peek(foot) + psz);
         end
      end
      return STAT_DONE;
   endfunction

   always @(posedge clock) begin
      rsp_type e, p;
      int errs;
      errs = 0;
      if (reset) begin
         foreach (heap_image[i]) heap_image[i] = '0;
         format_image();
         expected_rsp.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         // check a result strobe against the oldest prediction
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected result transaction");
               errs++;
            end else begin
               e = expected_rsp.pop_front();
               if (e.payload_offset !== rsp_data.payload_offset) begin
                  $error("payload_offset expected %0d actual %0d",
                         e.payload_offset, rsp_data.payload_offset);
                  errs++;
               end
               if (e.status !== rsp_data.status) begin
                  $error("status expected %0d actual %0d", e.status, rsp_data.status);
                  errs++;
               end
            end
         end
         // predict an accepted request transaction
         if (start && !busy) begin
            p = '0;
            case (req_data.command)
               CMD_ALLOC:  p = allocate_block(32'(req_data.request_bytes));
               CMD_FREE:   p.status = free_block(32'(req_data.block_offset));
               CMD_FORMAT: begin
                  format_image();
                  p.status = STAT_DONE;
               end
               default:    p.status = STAT_IGN;
            endcase
            expected_rsp.push_back(p);
         end
         fail_count <= fail_count + errs;
         pending <= expected_rsp.size();
      end
   end
endmodule

// ===== test/testbench.sv =====
// Stimulus top for the best-fit heap allocator core: drives requests with
// random gaps and reports the verdict. Depends on bfha_pkg and bfha_checker.
`timescale 1ns / 1ps
module testbench;
   import bfha_pkg::*;

   localparam int HEAP_BYTES = 4096;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;

   logic [15:0] live_offsets [$];

   best_fit_heap_allocator_core #(.HEAP_BYTES(HEAP_BYTES)) i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   bfha_checker #(.HEAP_BYTES(HEAP_BYTES)) i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // collect granted offsets so later frees hit live blocks
   always @(posedge clock)
      if (!reset && rsp_valid && rsp_data.status == STAT_DONE &&
          rsp_data.payload_offset != 0)
         live_offsets.push_back(rsp_data.payload_offset);

   // issue one transaction and hold until accepted; start stays high after
   // acceptance until the next call or the caller drops it
   task automatic send(logic [1:0] cmd, logic [15:0] bytes, logic [15:0] off);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= '{command: cmd, request_bytes: bytes, block_offset: off};
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic free_live();
      int k;
      if (live_offsets.size() == 0) send(CMD_FREE, 16'd8, 16'd8);
      else begin
         k = $urandom_range(0, live_offsets.size() - 1);
         send(CMD_FREE, 16'd0, live_offsets[k]);
         live_offsets.delete(k);
      end
   endtask

   initial begin
      int roll;
      logic [15:0] sz;
      start = 0;
      req_data = '0;
      reset = 1;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, every command, reject cases
      send(CMD_ALLOC, 16'd0, 16'hFFFF);
      send(CMD_ALLOC, 16'hFFFF, 16'd0);
      send(CMD_ALLOC, 16'd4088, 16'd0);
      send(CMD_FREE, 16'd0, 16'd8);
      send(CMD_FREE, 16'd0, 16'd8);
      send(CMD_FORMAT, 16'd0, 16'd0);
      send(CMD_ALLOC, 16'd4084, 16'd0);
      send(CMD_ALLOC, 16'd1, 16'd0);
      send(CMD_FORMAT, 16'hFFFF, 16'hFFFF);
      live_offsets.delete();
      send(CMD_ALLOC, 16'd1, 16'd0);
      send(CMD_ALLOC, 16'd12, 16'd0);
      send(CMD_ALLOC, 16'd100, 16'd0);
      send(CMD_FREE, 16'd0, 16'd12);
      send(CMD_FREE, 16'd0, 16'd0);
      send(CMD_FREE, 16'd0, 16'hFFF8);
      send(CMD_FREE, 16'd0, 16'd4096);
      send(CMD_FREE, 16'd0, 16'd4);
      send(2'd3, 16'hFFFF, 16'hFFFF);
      send(CMD_FREE, 16'd0, 16'd8);
      send(CMD_ALLOC, 16'd4, 16'd0);
      send(CMD_FREE, 16'd0, 16'd24);
      // random: mostly allocate and free of live blocks
      for (int n = 0; n < 1150; n++) begin
         roll = $urandom_range(0, 99);
         case ($urandom_range(0, 9))
            0: sz = 16'($urandom);
            1, 2: sz = 16'($urandom_range(0, 16));
            default: sz = 16'($urandom_range(1, 300));
         endcase
         if (roll < 50) send(CMD_ALLOC, sz, 16'($urandom));
         else if (roll < 88) free_live();
         else if (roll < 95) send(CMD_FREE, 16'($urandom), 16'($urandom));
         else if (roll < 98) send(CMD_FREE, 16'($urandom), 16'($urandom_range(0, 4100)));
         else if (roll < 99) begin
            start <= 1'b0;
            @(posedge clock);
            while (busy || pending != 0) @(posedge clock);
            live_offsets.delete();
            send(CMD_FORMAT, 16'($urandom), 16'($urandom));
         end else send(2'd3, 16'($urandom), 16'($urandom));
      end
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/bfha_pkg.sv
rtl/bfha_ram.sv
rtl/best_fit_heap_allocator_core.sv
test/bfha_checker.sv
test/testbench.sv
